// ===== src/lru_set_associative_cache_sim_unit_defines.svh =====
// assertion macros shared by the checker
`ifndef LRU_SET_ASSOCIATIVE_CACHE_SIM_UNIT_DEFINES_SVH
`define LRU_SET_ASSOCIATIVE_CACHE_SIM_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LSAC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cache sim assertion failed");

// next-cycle implication, disabled in reset
`define LSAC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache sim assertion failed");

`endif

// ===== src/lsac_pkg.sv =====
// ----------------------------------------------------------------------------
// lsac_pkg
// Shared types and codes of the set-associative LRU cache simulator.
// ----------------------------------------------------------------------------
package lsac_pkg;

    localparam int DEF_MAX_SET_BITS = 6;
    localparam int DEF_MAX_WAYS     = 8;

    // command codes
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_STORE  = 2'd1;
    localparam logic [1:0] CMD_MODIFY = 2'd2;

    // outcome codes
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_MISS  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    // register indexes
    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_WAYS       = 2'd1;
    localparam logic [1:0] REG_OFFSET_BITS = 2'd2;

    localparam logic [31:0] COUNT_MAX = 32'hffff_ffff;

    typedef struct packed {
        logic [2:0] set_bits;
        logic [3:0] ways;
        logic [4:0] offset_bits;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic        last;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
    } res_t;

    typedef enum logic {
        BS_IDLE,
        BS_EXEC
    } bst_t;

endpackage

// ===== src/lsac_ram.sv =====
// ----------------------------------------------------------------------------
// lsac_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module lsac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/lsac_front.sv =====
// ----------------------------------------------------------------------------
// lsac_front
// Splits each address into set and tag and holds the items in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module lsac_front
    import lsac_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          push,
    output logic          full,
    input  logic [1:0]    command,
    input  logic [31:0]   address,
    output logic          q_valid,
    input  logic          q_pop,
    output logic [SW-1:0] q_set,
    output logic [31:0]   q_tag,
    output logic          q_two
);

    logic [3:0]    sbits;
    logic [5:0]    tag_shift;
    logic [31:0]   shifted;
    logic [31:0]   set_mask;
    logic [31:0]   set_wide;
    logic [SW-1:0] set_c;
    logic [31:0]   tag_c;
    logic          accept;

    logic [SW-1:0] set_q [2];
    logic [31:0]   tag_q [2];
    logic          two_q [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    // address split
    always_comb
    begin
        if ({1'b0, cfg.set_bits} > 4'(MAX_SET_BITS))
            sbits = 4'(MAX_SET_BITS);
        else
            sbits = {1'b0, cfg.set_bits};
        shifted   = address >> cfg.offset_bits;
        set_mask  = (32'd1 << sbits) - 32'd1;
        set_wide  = shifted & set_mask;
        set_c     = set_wide[SW-1:0];
        tag_shift = {1'b0, cfg.offset_bits} + {2'b00, sbits};
        tag_c     = (tag_shift >= 6'd32) ? 32'd0 : (address >> tag_shift);
    end

    assign full    = count_reg[1];
    assign accept  = push && !full;
    assign q_valid = (count_reg != 2'd0);
    assign q_set   = set_q[rd_ptr_reg];
    assign q_tag   = tag_q[rd_ptr_reg];
    assign q_two   = two_q[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (accept && !q_pop)
            count_next = count_reg + 2'd1;
        else if (!accept && q_pop)
            count_next = count_reg - 2'd1;
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_q[wr_ptr_reg] <= set_c;
            tag_q[wr_ptr_reg] <= tag_c;
            two_q[wr_ptr_reg] <= (command == CMD_MODIFY);
        end
    end

endmodule

// ===== src/lsac_resq.sv =====
// ----------------------------------------------------------------------------
// lsac_resq
// Two-entry result queue in front of the output ports.
// ----------------------------------------------------------------------------
module lsac_resq
    import lsac_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  res_t wr_word,
    output logic wr_full,
    input  logic pop,
    output logic empty,
    output res_t rd_word
);

    res_t       buf_q [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_pop;

    assign wr_full = count_reg[1];
    assign empty   = (count_reg == 2'd0);
    assign do_pop  = pop && !empty;
    assign rd_word = buf_q[rd_ptr_reg];

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (wr_en && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (!wr_en && do_pop)
                count_reg <= count_reg - 2'd1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            buf_q[wr_ptr_reg] <= wr_word;
    end

endmodule

// ===== src/lsac_back.sv =====
// ----------------------------------------------------------------------------
// lsac_back
// Carries out accesses: reads one set row, does lookup, fill or eviction
// with LRU update, writes the row back and updates the counters.
// ----------------------------------------------------------------------------
module lsac_back
    import lsac_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS,
    parameter int SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          q_valid,
    input  logic [SW-1:0] q_set,
    input  logic [31:0]   q_tag,
    input  logic          q_two,
    output logic          q_pop,
    input  logic          res_full,
    output logic          res_push,
    output res_t          res_word
);

    localparam int NS = 1 << MAX_SET_BITS;
    localparam int RW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WI = RW;
    localparam int LW = 32 + RW + 1;
    localparam int W  = MAX_WAYS * LW;

    bst_t          state_reg;
    bst_t          state_next;
    logic          phase_reg;
    logic          phase_next;
    logic [NS-1:0] rowv_reg;
    logic          rowv_q_reg;
    logic [31:0]   hits_reg;
    logic [31:0]   misses_reg;
    logic [31:0]   evicts_reg;

    logic          rd_en;
    logic          wr_en;
    logic [W-1:0]  rd_row;
    logic [W-1:0]  wr_row;

    logic [MAX_WAYS-1:0] v;
    logic [31:0]         t [MAX_WAYS];
    logic [RW-1:0]       r [MAX_WAYS];
    logic [MAX_WAYS-1:0] hit_vec;
    logic                hit;
    logic [WI-1:0]       hit_way;
    logic                free_found;
    logic [WI-1:0]       free_way;
    logic                vic_found;
    logic [WI-1:0]       vic_way;
    logic [4:0]          ways_c;
    logic [4:0]          occ;
    logic                fill;
    logic [WI-1:0]       hot;
    logic                age_all;
    logic [RW-1:0]       old_rank;
    logic [1:0]          outcome;
    logic                last;
    logic                exec;

    lsac_ram #(
        .WIDTH (W),
        .DEPTH (NS),
        .AW    (SW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (q_set),
        .wr_data (wr_row),
        .rd_en   (rd_en),
        .rd_addr (q_set),
        .rd_data (rd_row)
    );

    // unpack the row; a never-written row reads empty
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            t[w] = rd_row[w*LW +: 32];
            r[w] = rowv_q_reg ? rd_row[w*LW+32 +: RW] : '0;
            v[w] = rowv_q_reg & rd_row[w*LW+32+RW];
        end
    end

    // lookup, free way and victim search
    always_comb
    begin
        hit        = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        vic_found  = 1'b0;
        vic_way    = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            hit_vec[w] = v[w] && (t[w] == q_tag);
            if (hit_vec[w] && !hit)
            begin
                hit     = 1'b1;
                hit_way = WI'(w);
            end
            if (!v[w] && !free_found)
            begin
                free_found = 1'b1;
                free_way   = WI'(w);
            end
            if (v[w] && (!vic_found || r[w] > r[vic_way]))
            begin
                vic_found = 1'b1;
                vic_way   = WI'(w);
            end
        end
    end

    // replacement choice
    always_comb
    begin
        if (cfg.ways == 4'd0)
            ways_c = 5'd1;
        else if ({1'b0, cfg.ways} > 5'(MAX_WAYS))
            ways_c = 5'(MAX_WAYS);
        else
            ways_c = {1'b0, cfg.ways};
        occ  = 5'($countones(v));
        fill = !hit && (occ < ways_c) && free_found;
        if (hit)
        begin
            hot      = hit_way;
            age_all  = 1'b0;
            old_rank = r[hit_way];
            outcome  = OUT_HIT;
        end
        else if (fill)
        begin
            hot      = free_way;
            age_all  = 1'b1;
            old_rank = '0;
            outcome  = OUT_MISS;
        end
        else
        begin
            hot      = vic_way;
            age_all  = 1'b0;
            old_rank = r[vic_way];
            outcome  = OUT_EVICT;
        end
    end

    // row write-back with recency update
    always_comb
    begin
        wr_row = rd_row;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            wr_row[w*LW+32 +: RW] = r[w];
            wr_row[w*LW+32+RW]    = v[w];
            if (WI'(w) == hot)
            begin
                wr_row[w*LW+32 +: RW] = '0;
                wr_row[w*LW+32+RW]    = 1'b1;
                if (!hit)
                    wr_row[w*LW +: 32] = q_tag;
            end
            else if (v[w] && (age_all || r[w] < old_rank))
            begin
                wr_row[w*LW+32 +: RW] = r[w] + RW'(1);
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        rd_en      = 1'b0;
        exec       = 1'b0;
        q_pop      = 1'b0;
        last       = !q_two || phase_reg;
        case (state_reg)
            BS_IDLE:
            begin
                if (q_valid)
                begin
                    rd_en      = 1'b1;
                    state_next = BS_EXEC;
                end
            end
            BS_EXEC:
            begin
                if (!res_full)
                begin
                    exec       = 1'b1;
                    state_next = BS_IDLE;
                    if (last)
                    begin
                        q_pop      = 1'b1;
                        phase_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    assign wr_en    = exec;
    assign res_push = exec;

    // result word carries the counts after this access
    always_comb
    begin
        res_word.outcome   = outcome;
        res_word.last      = last;
        res_word.hits      = hits_reg;
        res_word.misses    = misses_reg;
        res_word.evictions = evicts_reg;
        if (hit && hits_reg != COUNT_MAX)
            res_word.hits = hits_reg + 32'd1;
        if (!hit && misses_reg != COUNT_MAX)
            res_word.misses = misses_reg + 32'd1;
        if (!hit && !fill && evicts_reg != COUNT_MAX)
            res_word.evictions = evicts_reg + 32'd1;
    end

    // state, counters and row valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BS_IDLE;
            phase_reg  <= 1'b0;
            rowv_reg   <= '0;
            rowv_q_reg <= 1'b0;
            hits_reg   <= '0;
            misses_reg <= '0;
            evicts_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (rd_en)
                rowv_q_reg <= rowv_reg[q_set];
            if (exec)
            begin
                rowv_reg[q_set] <= 1'b1;
                hits_reg        <= res_word.hits;
                misses_reg      <= res_word.misses;
                evicts_reg      <= res_word.evictions;
            end
        end
    end

endmodule

// ===== src/lru_set_associative_cache_sim_unit.sv =====
// ----------------------------------------------------------------------------
// lru_set_associative_cache_sim_unit
// Set-associative cache simulator with true LRU replacement and saturating
// hit, miss and eviction counters.
//
//   channel   handshake        words
//   input     push / full      command, address
//   result    empty / pop      outcome, last_of_item, hit/miss/eviction totals
//   config    cfg_wr_en        cfg_index, cfg_data
//
// Each access in the back end reads the set row, then does lookup and
// write-back of the row; a modify makes two accesses.
// The front queue takes new words while the back end works.
// Reset clears all line valid flags (one flag per set row) and counters at once.
// A full result queue stalls the back end; a full front queue raises full.
// ----------------------------------------------------------------------------
module lru_set_associative_cache_sim_unit
    import lsac_pkg::*;
#(
    parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
    parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [31:0] address,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  outcome,
    output logic        last_of_item,
    output logic [31:0] hit_total,
    output logic [31:0] miss_total,
    output logic [31:0] eviction_total
);

    localparam int SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

    cfg_t          cfg_reg;
    logic          q_valid;
    logic          q_pop;
    logic [SW-1:0] q_set;
    logic [31:0]   q_tag;
    logic          q_two;
    logic          res_full;
    logic          res_push;
    res_t          res_in;
    res_t          res_out;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_bits    <= 3'd4;
            cfg_reg.ways        <= 4'd1;
            cfg_reg.offset_bits <= 5'd4;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SET_BITS:    cfg_reg.set_bits    <= cfg_data[2:0];
                REG_WAYS:        cfg_reg.ways        <= cfg_data[3:0];
                REG_OFFSET_BITS: cfg_reg.offset_bits <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    lsac_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .SW           (SW)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .push    (push),
        .full    (full),
        .command (command),
        .address (address),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_set   (q_set),
        .q_tag   (q_tag),
        .q_two   (q_two)
    );

    lsac_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .SW           (SW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_set    (q_set),
        .q_tag    (q_tag),
        .q_two    (q_two),
        .q_pop    (q_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_word (res_in)
    );

    lsac_resq u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_word (res_in),
        .wr_full (res_full),
        .pop     (pop),
        .empty   (empty),
        .rd_word (res_out)
    );

    assign outcome        = res_out.outcome;
    assign last_of_item   = res_out.last;
    assign hit_total      = res_out.hits;
    assign miss_total     = res_out.misses;
    assign eviction_total = res_out.evictions;

endmodule

// ===== src/lsac_checker.sv =====
// ----------------------------------------------------------------------------
// lsac_port_checker
// Port-level checks on the result side of the cache simulator.
// ----------------------------------------------------------------------------
`include "lru_set_associative_cache_sim_unit_defines.svh"

module lsac_port_checker
    import lsac_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  outcome,
    input logic [31:0] hit_total,
    input logic [31:0] miss_total,
    input logic [31:0] eviction_total
);

    // a waiting word stays until taken
    `LSAC_ASSERT_NEXT(a_hold, !empty && !pop, !empty)
    // and its hit and miss totals hold still
    `LSAC_ASSERT_NEXT(a_stable, !empty && !pop, $stable(hit_total) && $stable(miss_total))
    // an eviction is also a miss and was counted
    `LSAC_ASSERT_NOW(a_evict_cnt, !empty && outcome == OUT_EVICT,
        eviction_total != 32'd0 && miss_total != 32'd0)
    // a hit was counted
    `LSAC_ASSERT_NOW(a_hit_cnt, !empty && outcome == OUT_HIT, hit_total != 32'd0)

endmodule

bind lru_set_associative_cache_sim_unit lsac_port_checker u_lsac_checker (.*);
